// ===== rtl/core/wse_pkg.sv =====
package wse_pkg;

  // Field and datapath widths
  localparam int VAL_W  = 32;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 5;
  localparam int DV_W   = VAL_W + 1;
  localparam int TICK_W = 20;
  localparam int NUM_W  = 52;
  localparam int DEN_W  = TIME_W;

  // Defaults and fixed constants
  localparam int WINDOW_MAX_DEF = 16;
  localparam logic [CFG_W-1:0]  CFG_RESET        = 5'd16;
  localparam logic [TICK_W-1:0] TICKS_PER_SECOND = 20'd1000000;
  localparam logic [VAL_W-1:0]  SLOPE_MAX        = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0]  SLOPE_MIN        = 32'h8000_0000;

  // Input request payload
  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic [TIME_W-1:0]       sample_time;
  } sample_t;

  // Result request payload
  typedef struct packed {
    logic signed [VAL_W-1:0] slope;
    logic                    window_full;
    logic                    zero_span;
    logic                    clipped;
  } result_t;

  // Ring control and status
  typedef struct packed {
    logic push;
    logic clear;
  } ring_ctl_t;

  typedef struct packed {
    logic full;
    logic single;
  } ring_stat_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_FIX
  } state_t;

endpackage

// ===== rtl/core/wse_ring.sv =====
module wse_ring #(
  parameter int WINDOW_MAX = wse_pkg::WINDOW_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  wse_pkg::ring_ctl_t          ctl,
  input  logic [wse_pkg::CFG_W-1:0]   cfg_len,
  input  logic [wse_pkg::VAL_W-1:0]   wr_value,
  input  logic [wse_pkg::TIME_W-1:0]  wr_time,
  output logic [wse_pkg::VAL_W-1:0]   rd_value,
  output logic [wse_pkg::TIME_W-1:0]  rd_time,
  output wse_pkg::ring_stat_t         stat
);

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (CNT_W > wse_pkg::CFG_W) ? CNT_W : wse_pkg::CFG_W;
  localparam int AW    = CMP_W + 1;
  localparam int ENT_W = wse_pkg::VAL_W + wse_pkg::TIME_W;

  logic [ENT_W-1:0] mem [WINDOW_MAX];
  logic [ENT_W-1:0] rd_q;

  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] slot_next;
  logic [CMP_W-1:0] fill;
  logic [CMP_W-1:0] fill_next;
  logic [CMP_W-1:0] len_raw;
  logic [CMP_W-1:0] len;
  logic [AW-1:0]    newest_ext;
  logic [AW-1:0]    lenm1_ext;
  logic [AW-1:0]    oldest_ext;
  logic [IDX_W-1:0] rd_addr;

  // Clamp the window length to one through the ring depth
  always_comb begin
    len_raw = CMP_W'(cfg_len);
    if (len_raw == '0) begin
      len = CMP_W'(1);
    end else if (len_raw > CMP_W'(WINDOW_MAX)) begin
      len = CMP_W'(WINDOW_MAX);
    end else begin
      len = len_raw;
    end
  end

  // Locate the oldest sample of the window, wrapping around the ring
  always_comb begin
    newest_ext = AW'(slot);
    lenm1_ext  = AW'(len) - AW'(1);
    if (newest_ext >= lenm1_ext) begin
      oldest_ext = newest_ext - lenm1_ext;
    end else begin
      oldest_ext = newest_ext + AW'(WINDOW_MAX) - lenm1_ext;
    end
    rd_addr = oldest_ext[IDX_W-1:0];
  end

  // Advance the write slot and the saturating fill count
  always_comb begin
    if (slot == IDX_W'(WINDOW_MAX - 1)) begin
      slot_next = '0;
    end else begin
      slot_next = slot + IDX_W'(1);
    end
    if (fill < len) begin
      fill_next = fill + CMP_W'(1);
    end else begin
      fill_next = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      fill <= '0;
      stat <= '0;
    end else if (ctl.clear) begin
      fill <= '0;
    end else if (ctl.push) begin
      slot        <= slot_next;
      fill        <= fill_next;
      stat.full   <= (fill_next >= len);
      stat.single <= (len == CMP_W'(1));
    end
  end

  // Store the new sample and fetch the oldest one
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[slot] <= {wr_value, wr_time};
      rd_q      <= mem[rd_addr];
    end
  end

  assign rd_value = rd_q[ENT_W-1:wse_pkg::TIME_W];
  assign rd_time  = rd_q[wse_pkg::TIME_W-1:0];

endmodule

// ===== rtl/core/wse_div.sv =====
module wse_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [wse_pkg::NUM_W-1:0]  num,
  input  logic [wse_pkg::DEN_W-1:0]  den,
  output logic [wse_pkg::NUM_W-1:0]  quot,
  output wse_pkg::div_stat_t         stat
);

  localparam int NUM_W = wse_pkg::NUM_W;
  localparam int DEN_W = wse_pkg::DEN_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] qn;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;
  logic             fits;

  // Shared subtract-and-compare step of the restoring divider
  always_comb begin
    trial = {rem, qn[NUM_W-1]};
    diff  = {1'b0, trial} - {2'b00, dsr};
    fits  = !diff[DEN_W+1];
  end

  assign stat.busy = busy;
  assign stat.done = busy && (cnt == CNT_W'(NUM_W - 1));
  assign quot      = qn;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (stat.done) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift one quotient bit in per step
  always_ff @(posedge clk) begin
    if (start) begin
      qn  <= num;
      rem <= '0;
      dsr <= den;
    end else if (busy) begin
      qn <= {qn[NUM_W-2:0], fits};
      if (fits) begin
        rem <= diff[DEN_W-1:0];
      end else begin
        rem <= trial[DEN_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/windowed_slope_estimator_top.sv =====
// From an accepted input request the sequencer runs ST_DIFF, ST_MUL, ST_START, ST_DIV
// (the 52-step radix-2 divider) and ST_FIX when a slope is computed, or ST_DIFF and ST_FIX
// when the window is not yet full or the time span is zero. A new sample is taken only in
// ST_IDLE; a finished result waits in the output register while the next sample is taken.
// Reset (rst, synchronous): clears sequencer, output valid, write slot and fill count,
// and sets window_length to 16; the sample ring is not cleared.
module windowed_slope_estimator_top #(
  parameter int WINDOW_MAX = wse_pkg::WINDOW_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  wse_pkg::sample_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output wse_pkg::result_t           out_data,
  input  logic                       cfg_we,
  input  logic [wse_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int VAL_W  = wse_pkg::VAL_W;
  localparam int TIME_W = wse_pkg::TIME_W;
  localparam int DV_W   = wse_pkg::DV_W;
  localparam int NUM_W  = wse_pkg::NUM_W;
  localparam int PROD_W = DV_W + wse_pkg::TICK_W;

  wse_pkg::state_t     state;
  wse_pkg::state_t     state_next;
  wse_pkg::ring_ctl_t  ring_ctl;
  wse_pkg::ring_stat_t ring_stat;
  wse_pkg::div_stat_t  div_stat;

  logic [wse_pkg::CFG_W-1:0] window_length;
  logic [VAL_W-1:0]          new_value;
  logic [TIME_W-1:0]         new_time;
  logic [VAL_W-1:0]          old_value;
  logic [TIME_W-1:0]         old_time;

  logic [DV_W-1:0]   dv;
  logic [TIME_W-1:0] dt;
  logic [DV_W-1:0]   dv_mag;
  logic [TIME_W-1:0] dt_mag;
  logic              neg;
  logic              zspan;
  logic              full;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  quot;
  logic              div_start;
  logic              accept;
  logic              load_out;
  logic              fix_clip;
  logic [VAL_W-1:0]  fix_slope;

  assign accept = in_valid && in_ready;

  // Hold the window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= wse_pkg::CFG_RESET;
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
    end
  end

  assign ring_ctl.push  = accept;
  assign ring_ctl.clear = cfg_we;

  wse_ring #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ring_ctl),
    .cfg_len  (window_length),
    .wr_value (in_data.sample_value),
    .wr_time  (in_data.sample_time),
    .rd_value (old_value),
    .rd_time  (old_time),
    .stat     (ring_stat)
  );

  wse_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (dt_mag),
    .quot  (quot),
    .stat  (div_stat)
  );

  // Latch the newest sample of the request
  always_ff @(posedge clk) begin
    if (accept) begin
      new_value <= in_data.sample_value;
      new_time  <= in_data.sample_time;
    end
  end

  // Form the differences and their magnitudes
  always_comb begin
    dv = {new_value[VAL_W-1], new_value} - {old_value[VAL_W-1], old_value};
    dt = new_time - old_time;
  end

  always_ff @(posedge clk) begin
    if (state == wse_pkg::ST_DIFF) begin
      dv_mag <= dv[DV_W-1] ? (DV_W'(0) - dv) : dv;
      dt_mag <= dt[TIME_W-1] ? (TIME_W'(0) - dt) : dt;
      neg    <= dv[DV_W-1] ^ dt[TIME_W-1];
      zspan  <= ring_stat.single || (dt == '0);
      full   <= ring_stat.full;
    end
  end

  // Scale the value difference to ticks per second
  always_comb begin
    prod = PROD_W'(dv_mag) * PROD_W'(wse_pkg::TICKS_PER_SECOND);
  end

  always_ff @(posedge clk) begin
    if (state == wse_pkg::ST_MUL) begin
      num <= prod[NUM_W-1:0];
    end
  end

  // Saturate and sign the quotient magnitude
  always_comb begin
    fix_clip  = 1'b0;
    fix_slope = '0;
    if (full && !zspan) begin
      if (neg) begin
        fix_clip  = (quot > NUM_W'(wse_pkg::SLOPE_MIN));
        fix_slope = fix_clip ? wse_pkg::SLOPE_MIN : (VAL_W'(0) - quot[VAL_W-1:0]);
      end else begin
        fix_clip  = (quot[NUM_W-1:VAL_W-1] != '0);
        fix_slope = fix_clip ? wse_pkg::SLOPE_MAX : quot[VAL_W-1:0];
      end
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and controls
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      wse_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = wse_pkg::ST_DIFF;
        end
      end
      wse_pkg::ST_DIFF: begin
        if (!ring_stat.full || ring_stat.single || (dt == '0)) begin
          state_next = wse_pkg::ST_FIX;
        end else begin
          state_next = wse_pkg::ST_MUL;
        end
      end
      wse_pkg::ST_MUL: begin
        state_next = wse_pkg::ST_START;
      end
      wse_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = wse_pkg::ST_DIV;
      end
      wse_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = wse_pkg::ST_FIX;
        end
      end
      wse_pkg::ST_FIX: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = wse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wse_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold the result until the downstream request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.slope       <= fix_slope;
      out_data.window_full <= full;
      out_data.zero_span   <= full && zspan;
      out_data.clipped     <= fix_clip;
    end
  end

  // A taken sample blocks further requests until its result is formed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input taken while a sample is in progress");

  // Divider finishes only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == wse_pkg::ST_DIV))
    else $error("divider finished outside its wait state");

  // A partial window reports a plain zero
  a_partial_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.window_full) |->
      (out_data.slope == '0 && !out_data.zero_span && !out_data.clipped))
    else $error("partial window result not zero");

  // A zero span never clips and gives zero
  a_zero_span: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.zero_span) |-> (out_data.slope == '0 && !out_data.clipped))
    else $error("zero span result not zero");

  // A clipped slope sits on a bound
  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.clipped) |->
      (out_data.slope == wse_pkg::SLOPE_MAX || out_data.slope == wse_pkg::SLOPE_MIN))
    else $error("clipped slope off its bound");

endmodule
